@@ hw/rtl/multi_timer_table_assert.svh @@
// Assertion macros shared by the checker of the timer table.
`ifndef MULTI_TIMER_TABLE_ASSERT_SVH
`define MULTI_TIMER_TABLE_ASSERT_SVH

// Same-cycle implication, sampled on clk, switched off while rst_n is low.
`define MTT_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("multi_timer_table: same-cycle check failed");

// Next-cycle implication, sampled on clk, switched off while rst_n is low.
`define MTT_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("multi_timer_table: next-cycle check failed");

`endif

@@ hw/rtl/mtt_pkg.sv @@
// Package of the timer table: sizes, item codes and controller/datapath structs.
`timescale 1ns / 1ps
`default_nettype none

package mtt_pkg;

  localparam int TIMER_SLOTS  = 16;
  localparam int OWNER_BITS   = 8;
  localparam int OWNER_W      = 8;
  localparam int TIME_BITS    = 64;
  localparam int SLOT_BITS    = $clog2(TIMER_SLOTS);
  localparam int COUNT_BITS   = $clog2(TIMER_SLOTS + 1);
  localparam int NS_PER_US    = 1000;
  localparam int REM_BITS     = $clog2(NS_PER_US);
  localparam int DIV_CHUNK    = 16;
  localparam int DIV_STEPS    = TIME_BITS / DIV_CHUNK;
  localparam int DIV_CNT_BITS = $clog2(DIV_STEPS);

  // Reciprocal of NS_PER_US, scaled by 2^RECIP_SHIFT and rounded up; exact
  // for every partial dividend below NS_PER_US * 2^DIV_CHUNK.
  localparam int                    RECIP_SHIFT = 36;
  localparam int                    RECIP_BITS  = 27;
  localparam logic [RECIP_BITS-1:0] RECIP_MULT  = 27'd68719477;

  localparam logic [1:0] KIND_SET    = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_QUERY  = 2'd2;
  localparam logic [1:0] KIND_TICK   = 2'd3;

  localparam logic [2:0] ST_ARMED  = 3'd0;
  localparam logic [2:0] ST_FIRED  = 3'd1;
  localparam logic [2:0] ST_BLOCK  = 3'd2;
  localparam logic [2:0] ST_FULL   = 3'd3;
  localparam logic [2:0] ST_CANCEL = 3'd4;
  localparam logic [2:0] ST_QUERY  = 3'd5;
  localparam logic [2:0] ST_NONE   = 3'd6;

  typedef struct packed {
    logic       load;
    logic       div_step;
    logic       arm;
    logic       scan_step;
    logic       set_used;
    logic       emit;
    logic [2:0] emit_status;
    logic       emit_pend;
    logic       emit_last;
  } mtt_cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic       t_zero;
    logic       t_block;
    logic       full;
    logic       div_last;
    logic       scan_done;
    logic       drop_tick;
    logic       pend_v;
    logic       can_emit;
  } mtt_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/multi_timer_table.sv @@
// Top level of the timer table: controller and datapath joined by command and status.
// Zero, block and table-full sets give their item straight from the check state.
// An armed set goes through check, 4 division steps of 16 bits and arm before its result.
// Cancel, query and tick scan every used slot before their result; output stalls hold them.
// Throughput: one item at a time, set by the scan: one slot a cycle unless the output stalls.
// Reset (synchronous, rst_n low) clears time, fill count and handshake; slots are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module multi_timer_table (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [1:0]         in_kind,
  input  wire logic [7:0]         in_owner_id,
  input  wire logic signed [63:0] in_timeout_ns,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_status,
  output logic [7:0]              out_fired_owner,
  output logic                    out_present,
  output logic                    out_last
);

  // The controller decides what happens each cycle; the datapath holds all
  // the table state and reports back only a handful of status flags.
  mtt_pkg::mtt_cmd_t  cmd;
  mtt_pkg::mtt_stat_t stat;

  // Items are taken only in the idle state, but the result register in the
  // datapath lets a new item enter while the previous result still waits.
  mtt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Entries stay packed in insertion order: a scan reads slot by slot and
  // copies each survivor down to the write pointer. During a tick the latest
  // fired owner is held back in a pending register so that the final one can carry last.
  mtt_datapath u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_kind         (in_kind),
    .in_owner_id     (in_owner_id),
    .in_timeout_ns   (in_timeout_ns),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_fired_owner (out_fired_owner),
    .out_present     (out_present),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

@@ hw/rtl/mtt_datapath.sv @@
// Datapath of the timer table: slot store, time, divider, scan and result register.
`timescale 1ns / 1ps
`default_nettype none

module mtt_datapath (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire mtt_pkg::mtt_cmd_t            cmd,
  output mtt_pkg::mtt_stat_t                stat,
  input  wire logic [1:0]                   in_kind,
  input  wire logic [7:0]                   in_owner_id,
  input  wire logic signed [63:0]           in_timeout_ns,
  input  wire logic                         out_ready,
  output logic                              out_valid,
  output logic [2:0]                        out_status,
  output logic [7:0]                        out_fired_owner,
  output logic                              out_present,
  output logic                              out_last
);

  localparam int TB = mtt_pkg::TIME_BITS;
  localparam int OB = mtt_pkg::OWNER_BITS;
  localparam int CB = mtt_pkg::COUNT_BITS;
  localparam int SB = mtt_pkg::SLOT_BITS;
  localparam int RB = mtt_pkg::REM_BITS;
  localparam int CW = mtt_pkg::DIV_CHUNK;
  localparam int DW = RB + CW;
  localparam int PW = DW + mtt_pkg::RECIP_BITS;

  logic [1:0]                      kind_r;
  logic [OB-1:0]                   own_r;
  logic                            t_zero_r;
  logic                            t_block_r;
  logic                            neg_r;
  logic [TB-1:0]                   quo_r;
  logic [RB-1:0]                   rem_r;
  logic [mtt_pkg::DIV_CNT_BITS-1:0] div_cnt_r;
  logic [TB-1:0]                   now_r;
  logic [CB-1:0]                   used_r;
  logic [CB-1:0]                   scan_r;
  logic [CB-1:0]                   wr_r;
  logic                            has_r;
  logic                            pend_v_r;
  logic [OB-1:0]                   pend_own_r;
  logic [OB-1:0]                   slot_owner_r [mtt_pkg::TIMER_SLOTS];
  logic [TB-1:0]                   slot_exp_r   [mtt_pkg::TIMER_SLOTS];
  logic                            out_valid_r;
  logic [2:0]                      out_status_r;
  logic [mtt_pkg::OWNER_W-1:0]     out_owner_r;
  logic                            out_present_r;
  logic                            out_last_r;

  logic [TB-1:0] t_u;
  logic [TB-1:0] t_mag;
  logic [DW-1:0] dig;
  logic [PW-1:0] prod;
  logic [CW-1:0] dig_q;
  logic [RB-1:0] rem_nxt;
  logic [TB-1:0] expiry;
  logic [SB-1:0] rd_idx;
  logic [OB-1:0] rd_own;
  logic [TB-1:0] rd_exp;
  logic          match;
  logic          reached;
  logic          drop;
  logic          scan_done;
  logic [OB-1:0] emit_own;

  assign t_u   = in_timeout_ns;
  assign t_mag = t_u[TB-1] ? (~t_u + TB'(1)) : t_u;

  // Long division by the constant, one 16-bit chunk a cycle: the remainder
  // so far above the next chunk is divided by a reciprocal multiply.
  assign dig     = {rem_r, quo_r[TB-1 -: CW]};
  assign prod    = PW'(dig) * PW'(mtt_pkg::RECIP_MULT);
  assign dig_q   = prod[mtt_pkg::RECIP_SHIFT +: CW];
  assign rem_nxt = RB'(dig - DW'(dig_q) * DW'(mtt_pkg::NS_PER_US));

  // Sign of the quotient is applied as invert plus carry in the same add.
  assign expiry = now_r + (quo_r ^ {TB{neg_r}}) + TB'(neg_r);

  assign rd_idx    = scan_r[SB-1:0];
  assign rd_own    = slot_owner_r[rd_idx];
  assign rd_exp    = slot_exp_r[rd_idx];
  assign match     = rd_own == own_r;
  assign reached   = !($signed(now_r) < $signed(rd_exp));
  assign scan_done = scan_r == used_r;
  assign drop      = ((kind_r == mtt_pkg::KIND_CANCEL) && match) ||
                     ((kind_r == mtt_pkg::KIND_TICK) && reached);
  assign emit_own  = cmd.emit_pend ? pend_own_r : own_r;

  always_comb begin
    stat.kind      = kind_r;
    stat.t_zero    = t_zero_r;
    stat.t_block   = t_block_r;
    stat.full      = used_r == CB'(mtt_pkg::TIMER_SLOTS);
    stat.div_last  = div_cnt_r == mtt_pkg::DIV_CNT_BITS'(mtt_pkg::DIV_STEPS - 1);
    stat.scan_done = scan_done;
    stat.drop_tick = (kind_r == mtt_pkg::KIND_TICK) && reached && !scan_done;
    stat.pend_v    = pend_v_r;
    stat.can_emit  = !out_valid_r || out_ready;
  end

  // Item fields and working registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= in_kind;
      own_r     <= in_owner_id[OB-1:0];
      t_zero_r  <= t_u == '0;
      t_block_r <= &t_u;
      neg_r     <= t_u[TB-1];
      quo_r     <= t_mag;
      rem_r     <= '0;
      div_cnt_r <= '0;
      wr_r      <= '0;
      has_r     <= 1'b0;
    end else if (cmd.div_step) begin
      quo_r     <= {quo_r[TB-CW-1:0], dig_q};
      rem_r     <= rem_nxt;
      div_cnt_r <= div_cnt_r + mtt_pkg::DIV_CNT_BITS'(1);
    end else if (cmd.scan_step) begin
      if (!drop) begin
        wr_r <= wr_r + CB'(1);
      end
      if (match) begin
        has_r <= 1'b1;
      end
    end
    if (cmd.scan_step && drop) begin
      pend_own_r <= rd_own;
    end
  end

  // Control counters: time, fill count, scan pointer and pending fire.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r    <= '0;
      used_r   <= '0;
      scan_r   <= '0;
      pend_v_r <= 1'b0;
    end else begin
      if (cmd.load) begin
        scan_r   <= '0;
        pend_v_r <= 1'b0;
        if (in_kind == mtt_pkg::KIND_TICK) begin
          now_r <= now_r + TB'(1);
        end
      end else if (cmd.scan_step) begin
        scan_r <= scan_r + CB'(1);
        if (drop && (kind_r == mtt_pkg::KIND_TICK)) begin
          pend_v_r <= 1'b1;
        end
      end
      if (cmd.arm) begin
        used_r <= used_r + CB'(1);
      end else if (cmd.set_used) begin
        used_r <= wr_r;
      end
    end
  end

  // Slot store: append on arm, compacting copy during a scan.
  always_ff @(posedge clk) begin
    if (cmd.arm) begin
      slot_owner_r[used_r[SB-1:0]] <= own_r;
      slot_exp_r[used_r[SB-1:0]]   <= expiry;
    end else if (cmd.scan_step && !drop) begin
      slot_owner_r[wr_r[SB-1:0]] <= rd_own;
      slot_exp_r[wr_r[SB-1:0]]   <= rd_exp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r  <= cmd.emit_status;
      out_owner_r   <= (cmd.emit_status == mtt_pkg::ST_NONE) ? '0 :
                       mtt_pkg::OWNER_W'(emit_own);
      out_present_r <= (cmd.emit_status == mtt_pkg::ST_QUERY) && has_r;
      out_last_r    <= cmd.emit_last;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_fired_owner = out_owner_r;
  assign out_present     = out_present_r;
  assign out_last        = out_last_r;

endmodule

`default_nettype wire

@@ hw/rtl/mtt_ctrl.sv @@
// Controller of the timer table: sequences set, scan and result hand-off.
`timescale 1ns / 1ps
`default_nettype none

module mtt_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire logic [1:0]         in_kind,
  output logic                    in_ready,
  input  wire mtt_pkg::mtt_stat_t stat,
  output mtt_pkg::mtt_cmd_t       cmd
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_ARM   = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = (in_kind == mtt_pkg::KIND_SET) ? S_CHECK : S_SCAN;
        end
      end
      S_CHECK: begin
        if (stat.t_zero || stat.t_block || stat.full) begin
          if (stat.can_emit) begin
            cmd.emit        = 1'b1;
            cmd.emit_last   = 1'b1;
            cmd.emit_status = stat.t_zero  ? mtt_pkg::ST_FIRED :
                              stat.t_block ? mtt_pkg::ST_BLOCK : mtt_pkg::ST_FULL;
            state_nxt       = S_IDLE;
          end
        end else begin
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_nxt = S_ARM;
        end
      end
      S_ARM: begin
        if (stat.can_emit) begin
          cmd.arm         = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_last   = 1'b1;
          cmd.emit_status = mtt_pkg::ST_ARMED;
          state_nxt       = S_IDLE;
        end
      end
      S_SCAN: begin
        if (stat.scan_done) begin
          if (stat.can_emit) begin
            cmd.set_used  = 1'b1;
            cmd.emit      = 1'b1;
            cmd.emit_last = 1'b1;
            case (stat.kind)
              mtt_pkg::KIND_CANCEL: cmd.emit_status = mtt_pkg::ST_CANCEL;
              mtt_pkg::KIND_QUERY:  cmd.emit_status = mtt_pkg::ST_QUERY;
              default: begin
                cmd.emit_pend   = 1'b1;
                cmd.emit_status = stat.pend_v ? mtt_pkg::ST_FIRED : mtt_pkg::ST_NONE;
              end
            endcase
            state_nxt = S_IDLE;
          end
        end else if (!(stat.drop_tick && stat.pend_v && !stat.can_emit)) begin
          cmd.scan_step = 1'b1;
          // A new fire pushes the one held before it out, as not the last.
          if (stat.drop_tick && stat.pend_v) begin
            cmd.emit        = 1'b1;
            cmd.emit_pend   = 1'b1;
            cmd.emit_status = mtt_pkg::ST_FIRED;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/mtt_checker.sv @@
// Port-level checker of the timer table, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "multi_timer_table_assert.svh"

module mtt_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_status,
  input wire logic [7:0] out_fired_owner,
  input wire logic       out_present,
  input wire logic       out_last
);

  logic [12:0] result_bits;

  assign result_bits = {out_status, out_fired_owner, out_present, out_last};

  // A waiting result item holds still until it is taken.
  `MTT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(result_bits))

  // One item at a time: the block is busy straight after an acceptance.
  `MTT_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

  // Only a query answer may report a present timer.
  `MTT_ASSERT_IMP(a_present_query, out_valid && out_present, out_status == mtt_pkg::ST_QUERY)

  // Every result other than a fire is the single result of its item.
  `MTT_ASSERT_IMP(a_single_last, out_valid && (out_status != mtt_pkg::ST_FIRED), out_last)

endmodule

bind multi_timer_table mtt_checker u_mtt_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_fired_owner (out_fired_owner),
  .out_present     (out_present),
  .out_last        (out_last)
);

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the timer table: directed edge cases, then random traffic.
`timescale 1ns / 1ps

module testbench;

  // One result item as the block presents it on the out_ channel.
  typedef struct {
    logic [2:0] status;
    logic [7:0] owner;
    logic       present;
    logic       last;
  } timer_result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         in_kind;
  logic [7:0]         in_owner_id;
  logic signed [63:0] in_timeout_ns;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         out_status;
  logic [7:0]         out_fired_owner;
  logic               out_present;
  logic               out_last;

  multi_timer_table uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_kind         (in_kind),
    .in_owner_id     (in_owner_id),
    .in_timeout_ns   (in_timeout_ns),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_fired_owner (out_fired_owner),
    .out_present     (out_present),
    .out_last        (out_last)
  );

  // Our own copy of the timer table. Live entries are kept packed at the
  // bottom of the arrays in the order in which they were armed.
  logic [63:0]   now_us;
  logic [7:0]    timer_owner  [mtt_pkg::TIMER_SLOTS];
  logic [63:0]   timer_expiry [mtt_pkg::TIMER_SLOTS];
  int            timer_count;

  // Result items still owed by the block, oldest first.
  timer_result_t expected_results [$];
  timer_result_t want;
  int            mismatch_count;

  // Percentages of cycles in which the sender holds back or the receiver
  // stalls; each test phase sets its own.
  int            send_idle_pct;
  int            recv_stall_pct;

  localparam logic [63:0] TIMEOUT_NEVER   = '1;
  localparam logic [63:0] TIMEOUT_MAX_POS = {1'b0, {63{1'b1}}};
  localparam logic [63:0] TIMEOUT_MIN_NEG = {1'b1, {63{1'b0}}};

  // Free-running clock with an 8 ns period.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // A run that hangs is cut off here. Even a slow run with full tick bursts,
  // long sender gaps and heavy receiver stalling needs well under a tenth of
  // this, so the limit only ever catches a block that has stopped.
  initial begin
    #8_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // The receiver decides afresh each cycle whether it can take a result item.
  // With a zero stall rate it stays ready throughout, which gives the
  // stretches of back-to-back results.
  always @(posedge clk) begin
    if ($urandom_range(99) < recv_stall_pct) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Append one result item to the tail of the list of owed results.
  task automatic expect_result(input timer_result_t r);
    expected_results.insert(expected_results.size(), r);
  endtask

  // Work out what the block must produce for one accepted item, and update
  // our copy of the table to match. Timeouts are divided as signed values,
  // truncating toward zero, and expiry is compared with the current time as
  // a signed quantity, so negative timeouts land in the past.
  task automatic predict_item(input logic [1:0] kind, input logic [7:0] owner,
                              input logic [63:0] timeout);
    timer_result_t r;
    logic [7:0]    keep_owner  [mtt_pkg::TIMER_SLOTS];
    logic [63:0]   keep_expiry [mtt_pkg::TIMER_SLOTS];
    logic [7:0]    fired_owner [mtt_pkg::TIMER_SLOTS];
    int            kept;
    int            fired;
    r.owner   = owner;
    r.present = 1'b0;
    r.last    = 1'b1;
    kept      = 0;
    fired     = 0;
    case (kind)
      mtt_pkg::KIND_SET: begin
        // Immediate and block-forever timeouts never touch the table, so
        // they are answered even when every slot is taken.
        if (timeout == '0) begin
          r.status = mtt_pkg::ST_FIRED;
        end else if (timeout == TIMEOUT_NEVER) begin
          r.status = mtt_pkg::ST_BLOCK;
        end else if (timer_count >= mtt_pkg::TIMER_SLOTS) begin
          r.status = mtt_pkg::ST_FULL;
        end else begin
          timer_owner[timer_count]  = owner;
          timer_expiry[timer_count] = now_us + 64'($signed(timeout) / 64'sd1000);
          timer_count++;
          r.status = mtt_pkg::ST_ARMED;
        end
        expect_result(r);
      end
      mtt_pkg::KIND_CANCEL: begin
        for (int i = 0; i < timer_count; i++) begin
          if (timer_owner[i] != owner) begin
            keep_owner[kept]  = timer_owner[i];
            keep_expiry[kept] = timer_expiry[i];
            kept++;
          end
        end
        for (int i = 0; i < kept; i++) begin
          timer_owner[i]  = keep_owner[i];
          timer_expiry[i] = keep_expiry[i];
        end
        timer_count = kept;
        r.status    = mtt_pkg::ST_CANCEL;
        expect_result(r);
      end
      mtt_pkg::KIND_QUERY: begin
        for (int i = 0; i < timer_count; i++) begin
          if (timer_owner[i] == owner) r.present = 1'b1;
        end
        r.status = mtt_pkg::ST_QUERY;
        expect_result(r);
      end
      default: begin
        // A tick moves time on first, then fires every entry that is due,
        // in table order, and closes up the gaps it leaves.
        now_us = now_us + 64'd1;
        for (int i = 0; i < timer_count; i++) begin
          if ($signed(now_us) >= $signed(timer_expiry[i])) begin
            fired_owner[fired] = timer_owner[i];
            fired++;
          end else begin
            keep_owner[kept]  = timer_owner[i];
            keep_expiry[kept] = timer_expiry[i];
            kept++;
          end
        end
        for (int i = 0; i < kept; i++) begin
          timer_owner[i]  = keep_owner[i];
          timer_expiry[i] = keep_expiry[i];
        end
        timer_count = kept;
        if (fired == 0) begin
          r.status = mtt_pkg::ST_NONE;
          r.owner  = 8'd0;
          expect_result(r);
        end
        for (int j = 0; j < fired; j++) begin
          r.status = mtt_pkg::ST_FIRED;
          r.owner  = fired_owner[j];
          r.last   = (j == fired - 1);
          expect_result(r);
        end
      end
    endcase
  endtask

  // Offer one item on the in_ channel, after a random gap, and hold it until
  // the block takes it. The task is entered and left at a rising edge; valid
  // is left high on return so that a following item can go out back to back.
  // Ready is looked at mid-cycle, where it is settled, and the item counts as
  // taken at the rising edge that follows.
  task automatic send_item(input logic [1:0] kind, input logic [7:0] owner,
                           input logic [63:0] timeout);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_kind       <= kind;
    in_owner_id   <= owner;
    in_timeout_ns <= timeout;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    predict_item(kind, owner, timeout);
  endtask

  // Each result item is checked mid-cycle, where the outputs and ready are
  // stable; a valid with ready high here is taken at the next rising edge.
  always @(negedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("%0t: result item with none owed: status %0d owner %0d present %0b last %0b",
                   $realtime, out_status, out_fired_owner, out_present, out_last);
        end
      end else begin
        want = expected_results[0];
        expected_results.delete(0);
        if (out_status !== want.status || out_fired_owner !== want.owner ||
            out_present !== want.present || out_last !== want.last) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display(
              "%0t: exp/act status %0d/%0d owner %0d/%0d present %0b/%0b last %0b/%0b",
              $realtime, want.status, out_status, want.owner, out_fired_owner,
              want.present, out_present, want.last, out_last);
          end
        end
      end
    end
  end

  // Ticks on an empty table, immediate and block-forever sets, and the odd
  // timeouts: one microsecond, below one microsecond (armed but already due),
  // a negative value and the most negative value, which all fire together on
  // the next tick.
  task automatic test_edge_timeouts;
    send_item(mtt_pkg::KIND_TICK, 8'h00, '0);
    send_item(mtt_pkg::KIND_SET, 8'hFF, '0);
    send_item(mtt_pkg::KIND_SET, 8'h00, TIMEOUT_NEVER);
    send_item(mtt_pkg::KIND_SET, 8'hAA, 64'd1000);
    send_item(mtt_pkg::KIND_SET, 8'h55, 64'd999);
    send_item(mtt_pkg::KIND_SET, 8'h7F, -64'd5000);
    send_item(mtt_pkg::KIND_SET, 8'h01, TIMEOUT_MIN_NEG);
    send_item(mtt_pkg::KIND_TICK, 8'h00, '0);
  endtask

  // Fill every slot, alternating an owner whose timers never come due with
  // one whose timers come due on the next tick. A further set is then refused,
  // while immediate and block-forever sets are still answered. The tick fires
  // half the table out of the middle, and a cancel clears the rest.
  task automatic test_table_full;
    for (int i = 0; i < mtt_pkg::TIMER_SLOTS; i++) begin
      if (i % 2 == 0) begin
        send_item(mtt_pkg::KIND_SET, 8'h3C, TIMEOUT_MAX_POS);
      end else begin
        send_item(mtt_pkg::KIND_SET, 8'hC3, 64'd1999);
      end
    end
    send_item(mtt_pkg::KIND_SET, 8'h11, 64'd5000);
    send_item(mtt_pkg::KIND_SET, 8'h22, '0);
    send_item(mtt_pkg::KIND_SET, 8'h33, TIMEOUT_NEVER);
    send_item(mtt_pkg::KIND_QUERY, 8'hC3, '0);
    send_item(mtt_pkg::KIND_TICK, 8'h00, '0);
    send_item(mtt_pkg::KIND_CANCEL, 8'h3C, '0);
  endtask

  // Random traffic under one pair of idle rates. Most owners come from a
  // small pool so that cancels and queries find entries; timeouts that keep
  // an entry for a long time always use a pool owner, so that cancels keep
  // the table from silting up. Short timeouts dominate, so that ticks fire
  // entries often, sometimes several at once.
  task automatic test_random_traffic(input int send_pct, input int stall_pct,
                                     input int count);
    int          pick;
    logic [1:0]  kind;
    logic [7:0]  owner;
    logic [63:0] timeout;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 40) begin
        kind = mtt_pkg::KIND_SET;
      end else if (pick < 72) begin
        kind = mtt_pkg::KIND_TICK;
      end else if (pick < 84) begin
        kind = mtt_pkg::KIND_CANCEL;
      end else begin
        kind = mtt_pkg::KIND_QUERY;
      end
      if ($urandom_range(99) < 75) begin
        owner = 8'($urandom_range(0, 7));
      end else begin
        owner = 8'($urandom_range(0, 255));
      end
      timeout = '0;
      if (kind == mtt_pkg::KIND_SET) begin
        pick = $urandom_range(99);
        if (pick < 10) begin
          timeout = '0;
        end else if (pick < 18) begin
          timeout = TIMEOUT_NEVER;
        end else if (pick < 60) begin
          timeout = 64'($urandom_range(0, 20)) * 64'd1000 + 64'($urandom_range(0, 999));
        end else if (pick < 70) begin
          timeout = -64'($urandom_range(1, 30000));
        end else if (pick < 80) begin
          timeout = {$urandom, $urandom};
        end else if (pick < 88) begin
          timeout = TIMEOUT_MAX_POS - 64'($urandom_range(0, 1000));
        end else begin
          timeout = 64'($urandom_range(1, 100000));
        end
        if (pick >= 70 && !timeout[63]) owner = 8'($urandom_range(0, 7));
      end else if ($urandom_range(99) < 10) begin
        // The timeout is meaningless outside a set, so vary it there too.
        timeout = {$urandom, $urandom};
      end
      send_item(kind, owner, timeout);
    end
  endtask

  initial begin
    int drain_cycles;
    now_us         = '0;
    timer_count    = 0;
    mismatch_count = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_kind        <= mtt_pkg::KIND_SET;
    in_owner_id    <= 8'h00;
    in_timeout_ns  <= '0;
    out_ready      <= 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_edge_timeouts();
    test_table_full();
    test_random_traffic(0, 0, 98);
    test_random_traffic(48, 0, 98);
    test_random_traffic(0, 48, 98);
    test_random_traffic(37, 37, 98);
    in_valid <= 1'b0;

    // Let the last results come out, then allow for the longest latency
    // of the block in case anything stray follows.
    drain_cycles = 0;
    while (expected_results.size() != 0 && drain_cycles < 20000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (80) @(posedge clk);

    if (expected_results.size() != 0) begin
      $display("%0d expected result items never arrived", expected_results.size());
    end
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
